// File: rtl/lsr_pkg.sv
package lsr_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 64;
    localparam int unsigned WORD_WIDTH_DEF  = 32;

    // fixed field widths
    localparam int unsigned REQ_W     = 2;
    localparam int unsigned DEPTH_W   = 6;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned FILL_W    = 7;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_DEPTH = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic               push;        // all cells take the neighbor above
        logic               remove;      // cells at or below depth take the neighbor below
        logic               lane_load;   // copy entries into the read lane
        logic               lane_shift;  // read lane moves one cell toward the top
        logic [DEPTH_W-1:0] depth;
    } t_cell_ctl;

endpackage

// File: rtl/lsr_cell.sv
// One stack slot. Cell IDX holds the entry IDX places below the top.
module lsr_cell #(
    parameter int unsigned WORD_WIDTH = lsr_pkg::WORD_WIDTH_DEF,
    parameter int unsigned IDX        = 0
) (
    input  logic                  i_clk,
    input  lsr_pkg::t_cell_ctl    i_ctl,
    input  logic [WORD_WIDTH-1:0] i_up_entry,
    input  logic [WORD_WIDTH-1:0] i_dn_entry,
    input  logic [WORD_WIDTH-1:0] i_dn_lane,
    output logic [WORD_WIDTH-1:0] o_entry,
    output logic [WORD_WIDTH-1:0] o_lane
);

    logic [WORD_WIDTH-1:0] r_entry;
    logic [WORD_WIDTH-1:0] r_lane;
    logic                  w_at_or_below;

    assign w_at_or_below = (IDX >= int'(i_ctl.depth));

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_up_entry;
        end else if (i_ctl.remove && w_at_or_below) begin
            r_entry <= i_dn_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.lane_load) begin
            r_lane <= r_entry;
        end else if (i_ctl.lane_shift) begin
            r_lane <= i_dn_lane;
        end
    end

    assign o_entry = r_entry;
    assign o_lane  = r_lane;

endmodule

// File: rtl/lifo_stack_with_remove.sv
// LIFO stack of signed words built as a chain of cells, cell 0 holding the top.
// Push, pop, remove at depth and every refused request need no scan: the
// whole chain shifts up or down together, and the result lands in the output
// register the cycle after the transaction. A peek at depth d copies the
// entries into a read lane that moves one cell toward the top per cycle until
// the wanted word reaches cell 0; its result is registered from cell 0 of the
// lane, and the input stays closed while the lane moves. A new request is
// taken while the block is not scanning and the output register is empty or
// being drained in the same cycle. Exactly one result per request.
module lifo_stack_with_remove #(
    parameter int unsigned STACK_DEPTH = lsr_pkg::STACK_DEPTH_DEF,
    parameter int unsigned WORD_WIDTH  = lsr_pkg::WORD_WIDTH_DEF,
    localparam int unsigned IN_W  = ((WORD_WIDTH + lsr_pkg::DEPTH_W + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((WORD_WIDTH + lsr_pkg::STATUS_W + lsr_pkg::FILL_W + 1
                                      + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [IN_W-1:0]           i_s_tdata,   // push_value, depth_index, zero pad
    input  logic [lsr_pkg::REQ_W-1:0] i_s_tuser,   // req_type
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [OUT_W-1:0]          o_m_tdata    // read_value, status, fill_count,
                                                   // is_empty, zero pad
);

    localparam int unsigned CW   = $clog2(STACK_DEPTH + 1);
    localparam int unsigned CMPW = (CW > lsr_pkg::DEPTH_W) ? CW : lsr_pkg::DEPTH_W;

    lsr_pkg::t_state                 r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [lsr_pkg::DEPTH_W-1:0]     r_scan, n_scan;
    logic                            r_out_valid, n_out_valid;
    logic [WORD_WIDTH-1:0]           r_read, n_read;
    logic [lsr_pkg::STATUS_W-1:0]    r_status, n_status;
    lsr_pkg::t_cell_ctl              w_ctl;

    logic [WORD_WIDTH-1:0]           w_entry [STACK_DEPTH];
    logic [WORD_WIDTH-1:0]           w_lane  [STACK_DEPTH];

    logic                            w_acc;
    logic [lsr_pkg::REQ_W-1:0]       w_req;
    logic [WORD_WIDTH-1:0]           w_value;
    logic [lsr_pkg::DEPTH_W-1:0]     w_depth;
    logic                            w_full, w_empty, w_bad;

    assign w_req   = i_s_tuser;
    assign w_value = i_s_tdata[WORD_WIDTH-1:0];
    assign w_depth = i_s_tdata[WORD_WIDTH +: lsr_pkg::DEPTH_W];
    assign w_full  = (r_count == CW'(STACK_DEPTH));
    assign w_empty = (r_count == '0);
    assign w_bad   = (CMPW'(w_depth) >= CMPW'(r_count));

    assign o_s_tready = (r_state == lsr_pkg::ST_IDLE) && (!r_out_valid || i_m_tready);
    assign w_acc      = i_s_tvalid && o_s_tready;

    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_up, w_dn, w_dn_lane;
        if (k == 0) begin : g_top
            assign w_up = w_value;
        end else begin : g_mid
            assign w_up = w_entry[k-1];
        end
        if (k == STACK_DEPTH - 1) begin : g_bot
            assign w_dn      = '0;
            assign w_dn_lane = '0;
        end else begin : g_nbot
            assign w_dn      = w_entry[k+1];
            assign w_dn_lane = w_lane[k+1];
        end
        lsr_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .IDX        (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_up_entry (w_up),
            .i_dn_entry (w_dn),
            .i_dn_lane  (w_dn_lane),
            .o_entry    (w_entry[k]),
            .o_lane     (w_lane[k])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan      = r_scan;
        n_out_valid = r_out_valid && !i_m_tready;
        n_read      = r_read;
        n_status    = r_status;
        w_ctl       = '0;
        case (r_state)
            lsr_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_out_valid = 1'b1;
                    n_read      = '0;
                    n_status    = lsr_pkg::STS_OK;
                    case (w_req)
                        lsr_pkg::REQ_PUSH: begin
                            if (w_full) begin
                                n_status = lsr_pkg::STS_FULL;
                            end else begin
                                w_ctl.push = 1'b1;
                                n_count    = r_count + 1'b1;
                            end
                        end
                        lsr_pkg::REQ_POP: begin
                            if (w_empty) begin
                                n_status = lsr_pkg::STS_EMPTY;
                            end else begin
                                // pop is a removal at the top
                                w_ctl.remove = 1'b1;
                                n_read       = w_entry[0];
                                n_count      = r_count - 1'b1;
                            end
                        end
                        lsr_pkg::REQ_REMOVE: begin
                            if (w_bad) begin
                                n_status = lsr_pkg::STS_BAD_DEPTH;
                            end else begin
                                w_ctl.remove = 1'b1;
                                w_ctl.depth  = w_depth;
                                n_count      = r_count - 1'b1;
                            end
                        end
                        lsr_pkg::REQ_PEEK: begin
                            if (w_bad) begin
                                n_status = lsr_pkg::STS_BAD_DEPTH;
                            end else begin
                                n_out_valid     = 1'b0;
                                w_ctl.lane_load = 1'b1;
                                n_scan          = w_depth;
                                n_state         = lsr_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            n_status = lsr_pkg::STS_OK;
                        end
                    endcase
                end
            end
            lsr_pkg::ST_SCAN: begin
                if (r_scan == '0) begin
                    n_out_valid = 1'b1;
                    n_read      = w_lane[0];
                    n_status    = lsr_pkg::STS_OK;
                    n_state     = lsr_pkg::ST_IDLE;
                end else begin
                    w_ctl.lane_shift = 1'b1;
                    n_scan           = r_scan - 1'b1;
                end
            end
            default: begin
                n_state = lsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsr_pkg::ST_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read   <= n_read;
        r_status <= n_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({(r_count == '0), lsr_pkg::FILL_W'(r_count), r_status, r_read});

endmodule

// File: rtl/lsr_checker.sv
module lsr_checker #(
    parameter int unsigned STACK_DEPTH = lsr_pkg::STACK_DEPTH_DEF,
    parameter int unsigned WORD_WIDTH  = lsr_pkg::WORD_WIDTH_DEF,
    localparam int unsigned IN_W  = ((WORD_WIDTH + lsr_pkg::DEPTH_W + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((WORD_WIDTH + lsr_pkg::STATUS_W + lsr_pkg::FILL_W + 1
                                      + 7) / 8) * 8
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_tvalid,
    input logic                      o_s_tready,
    input logic [IN_W-1:0]           i_s_tdata,
    input logic [lsr_pkg::REQ_W-1:0] i_s_tuser,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [OUT_W-1:0]          o_m_tdata
);

    localparam int unsigned ST_LO = WORD_WIDTH;
    localparam int unsigned FC_LO = WORD_WIDTH + lsr_pkg::STATUS_W;
    localparam int unsigned EM_B  = FC_LO + lsr_pkg::FILL_W;

    logic [WORD_WIDTH-1:0]         w_read;
    logic [lsr_pkg::STATUS_W-1:0]  w_status;
    logic [lsr_pkg::FILL_W-1:0]    w_fill;
    logic                          w_is_empty;

    assign w_read     = o_m_tdata[WORD_WIDTH-1:0];
    assign w_status   = o_m_tdata[ST_LO +: lsr_pkg::STATUS_W];
    assign w_fill     = o_m_tdata[FC_LO +: lsr_pkg::FILL_W];
    assign w_is_empty = o_m_tdata[EM_B];

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_is_empty == (w_fill == '0)))
        else $error("is_empty disagrees with fill_count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_status == lsr_pkg::STS_FULL))
            |-> (w_fill == lsr_pkg::FILL_W'(STACK_DEPTH)))
        else $error("full status with stack not full");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (w_status != lsr_pkg::STS_OK)) |-> (w_read == '0))
        else $error("refused request returned data");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && !o_s_tready)
            |=> (i_s_tvalid && $stable(i_s_tdata) && $stable(i_s_tuser)))
        else $error("waiting request changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind lifo_stack_with_remove lsr_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
) u_lsr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// File: bench/testbench.sv
module testbench;

    localparam int IN_W           = 40;
    localparam int OUT_W          = 48;
    localparam int DEPTH          = int'(lsr_pkg::STACK_DEPTH_DEF);
    localparam int TOTAL_ITEMS    = 1750;
    localparam int TAIL_ITEMS     = 200;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct {
        logic signed [31:0]           read_value;
        logic [lsr_pkg::STATUS_W-1:0] status;
        logic [lsr_pkg::FILL_W-1:0]   fill_count;
        logic                         is_empty;
    } t_stack_result;

    class t_stack_scoreboard;
        logic signed [31:0] words [DEPTH];
        int                 fill;
        int                 mismatches;
        t_stack_result      pending_results [$];

        function new();
            fill = 0;
            mismatches = 0;
        endfunction

        // apply one accepted request to the shadow stack and queue its result
        function void note_request(logic [lsr_pkg::REQ_W-1:0] req, logic signed [31:0] value,
                                   logic [lsr_pkg::DEPTH_W-1:0] depth);
            t_stack_result r;
            int            pos;
            r.read_value = '0;
            r.status     = lsr_pkg::STS_OK;
            case (req)
                lsr_pkg::REQ_PUSH: begin
                    if (fill == DEPTH) begin
                        r.status = lsr_pkg::STS_FULL;
                    end else begin
                        words[fill] = value;
                        fill++;
                    end
                end
                lsr_pkg::REQ_POP: begin
                    if (fill == 0) begin
                        r.status = lsr_pkg::STS_EMPTY;
                    end else begin
                        fill--;
                        r.read_value = words[fill];
                    end
                end
                default: begin
                    if (int'(depth) >= fill) begin
                        r.status = lsr_pkg::STS_BAD_DEPTH;
                    end else begin
                        pos = fill - 1 - int'(depth);
                        if (req == lsr_pkg::REQ_PEEK) begin
                            r.read_value = words[pos];
                        end else begin
                            // entries above the removed one slide down
                            for (int k = pos; k + 1 < fill; k++) begin
                                words[k] = words[k + 1];
                            end
                            fill--;
                        end
                    end
                end
            endcase
            r.fill_count = fill[lsr_pkg::FILL_W-1:0];
            r.is_empty   = (fill == 0);
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            t_stack_result got;
            t_stack_result want;
            got.read_value = data[31:0];
            got.status     = data[33:32];
            got.fill_count = data[40:34];
            got.is_empty   = data[41];
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h", data);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.fill_count !== want.fill_count) begin
                $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
                mismatches++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                mismatches++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_tvalid;
    logic                      o_s_tready;
    logic [IN_W-1:0]           i_s_tdata;   // push_value, depth_index, zero pad
    logic [lsr_pkg::REQ_W-1:0] i_s_tuser;   // req_type
    logic                      o_m_tvalid;
    logic                      i_m_tready;
    logic [OUT_W-1:0]          o_m_tdata;   // read_value, status, fill_count, is_empty, zero pad

    t_stack_scoreboard sb;
    int                accepted_in = 0;
    bit                quiet = 0;

    lifo_stack_with_remove uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_request(input logic [lsr_pkg::REQ_W-1:0] req,
                                input logic signed [31:0] value,
                                input logic [lsr_pkg::DEPTH_W-1:0] depth);
        i_s_tvalid = 1'b1;
        i_s_tdata  = {2'b00, depth, value};
        i_s_tuser  = req;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(req, value, depth);
        accepted_in++;
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        i_s_tvalid = 1'b0;
        i_s_tdata  = {2'b00, 6'($urandom), 32'($urandom)};
        i_s_tuser  = 2'($urandom);
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic send_random(input int push_pct, input int pop_pct);
        logic [lsr_pkg::REQ_W-1:0]   req;
        logic signed [31:0]          value;
        logic [lsr_pkg::DEPTH_W-1:0] depth;
        int                          roll;
        int                          near_top;
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            req = lsr_pkg::REQ_PUSH;
        end else if (roll < push_pct + pop_pct) begin
            req = lsr_pkg::REQ_POP;
        end else if ($urandom_range(0, 1) == 0) begin
            req = lsr_pkg::REQ_REMOVE;
        end else begin
            req = lsr_pkg::REQ_PEEK;
        end
        case ($urandom_range(0, 9))
            0:       value = 32'sh7fff_ffff;
            1:       value = 32'sh8000_0000;
            2:       value = '0;
            3:       value = -32'sd1;
            default: value = $urandom;
        endcase
        depth = 6'($urandom_range(0, DEPTH - 1));
        if ((req == lsr_pkg::REQ_REMOVE || req == lsr_pkg::REQ_PEEK) && sb.fill > 0
                && $urandom_range(0, 9) != 0) begin
            // a deep peek scans the lane level by level, so keep most of them shallow
            near_top = (sb.fill < 8) ? sb.fill - 1 : 7;
            if ($urandom_range(0, 3) != 0) begin
                depth = 6'($urandom_range(0, near_top));
            end else begin
                depth = 6'($urandom_range(0, sb.fill - 1));
            end
        end
        send_request(req, value, depth);
    endtask

    initial begin
        int seg_len;
        int push_pct;
        int pop_pct;
        bit gappy;
        bit first_seg;
        sb         = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = lsr_pkg::REQ_PUSH;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty stack corners
        send_request(lsr_pkg::REQ_POP, 32'sd5, 6'd0);
        send_request(lsr_pkg::REQ_PEEK, 32'sd0, 6'd0);
        send_request(lsr_pkg::REQ_REMOVE, 32'sd0, 6'd63);
        send_request(lsr_pkg::REQ_PEEK, 32'sd0, 6'd63);
        // extremes of the word
        send_request(lsr_pkg::REQ_PUSH, 32'sh7fff_ffff, 6'd63);
        send_request(lsr_pkg::REQ_PUSH, 32'sh8000_0000, 6'd0);
        send_request(lsr_pkg::REQ_PUSH, 32'sd0, 6'd0);
        send_request(lsr_pkg::REQ_PUSH, -32'sd1, 6'd0);
        send_request(lsr_pkg::REQ_PUSH, 32'sh1234_5678, 6'd0);
        send_request(lsr_pkg::REQ_PEEK, 32'sd0, 6'd0);
        send_request(lsr_pkg::REQ_PEEK, 32'sd0, 6'd4);
        send_request(lsr_pkg::REQ_PEEK, 32'sd0, 6'd5);
        send_request(lsr_pkg::REQ_REMOVE, 32'sd0, 6'd5);
        send_request(lsr_pkg::REQ_REMOVE, 32'sd0, 6'd2);   // middle
        send_request(lsr_pkg::REQ_PEEK, 32'sd0, 6'd2);
        send_request(lsr_pkg::REQ_REMOVE, 32'sd0, 6'd0);   // top
        send_request(lsr_pkg::REQ_REMOVE, 32'sd0, 6'd2);   // bottom
        send_request(lsr_pkg::REQ_POP, 32'sd0, 6'd0);
        send_request(lsr_pkg::REQ_POP, 32'sd0, 6'd0);
        send_request(lsr_pkg::REQ_POP, 32'sd0, 6'd0);

        first_seg = 1'b1;
        while (accepted_in < TOTAL_ITEMS) begin
            seg_len = first_seg ? 120 : $urandom_range(40, 120);
            gappy   = $urandom_range(0, 2) != 0;
            case (first_seg ? 0 : $urandom_range(0, 2))
                0:       begin push_pct = 88; pop_pct = 2;  end   // toward full
                1:       begin push_pct = 15; pop_pct = 55; end   // toward empty
                default: begin push_pct = 35; pop_pct = 25; end
            endcase
            first_seg = 1'b0;
            repeat (seg_len) begin
                if (accepted_in >= TOTAL_ITEMS) break;
                quiet = accepted_in >= TOTAL_ITEMS - TAIL_ITEMS;
                if (!quiet && gappy && $urandom_range(0, 4) == 0) begin
                    idle_sender($urandom_range(1, 16));
                end
                send_random(push_pct, pop_pct);
            end
        end
        i_s_tvalid = 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // result side: random stalls, one long hold-off, none in the tail
    initial begin
        bit held;
        held       = 1'b0;
        i_m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (quiet) begin
                i_m_tready = 1'b1;
                @(negedge i_clk);
            end else if (!held && accepted_in >= HOLD_AFTER) begin
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b1;
                repeat ($urandom_range(1, 24)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata);
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

endmodule
